>>> sv/tgt_pkg.sv
// Shared types, gesture codes and register indexes of the touch gesture tracker.
package tgt_pkg;

   localparam int SLOT_W       = 3;
   localparam int COORD_W      = 16;
   localparam int TIME_W       = 32;
   localparam int STATE_W      = 4;
   localparam int CLICK_W      = 8;
   localparam int THR_W        = 8;
   localparam int HOLD_W       = 16;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;
   localparam int MAX_POINTS_DEFAULT = 8;

   // action codes
   localparam logic [1:0] ACT_PRESS   = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_TICK    = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FLICK_THR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME = 1'd1;

   localparam logic [THR_W-1:0]  FLICK_THR_RESET = 8'd8;
   localparam logic [HOLD_W-1:0] HOLD_TIME_RESET = 16'd500;

   // gesture state codes and bit masks
   localparam logic [STATE_W-1:0] ST_NONE        = 4'd0;
   localparam logic [STATE_W-1:0] ST_TOUCH       = 4'd1;
   localparam logic [STATE_W-1:0] ST_TOUCH_END   = 4'd2;
   localparam logic [STATE_W-1:0] ST_TOUCH_BEGIN = 4'd3;
   localparam logic [STATE_W-1:0] ST_HOLD_BEGIN  = 4'd7;
   localparam logic [STATE_W-1:0] ST_FLICK_BEGIN = 4'd11;
   localparam logic [STATE_W-1:0] M_TOUCH        = 4'd1;
   localparam logic [STATE_W-1:0] M_CHANGE       = 4'd2;
   localparam logic [STATE_W-1:0] M_MOVING       = 4'd8;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] prev_x;
      logic [COORD_W-1:0] prev_y;
      logic [COORD_W-1:0] base_x;
      logic [COORD_W-1:0] base_y;
      logic [TIME_W-1:0]  base_time;
      logic [CLICK_W-1:0] clicks;
      logic [COORD_W-1:0] size;
   } rec_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] contact_size;
      logic [TIME_W-1:0]  time_ms;
   } evt_type;

endpackage

>>> sv/touch_gesture_tracker_top.sv
// Top level of the touch gesture tracker: request pipeline, registers and result register.
//
// Each request carries one event for one touch slot (pressed sample, release or idle
// tick) and produces exactly one response with the slot's updated gesture state,
// positions, contact size, click count and whether the slot was active before the
// event. Slot records live in a small synchronous memory with a registered read: a
// request is accepted and its slot read into the memory's read register while the
// update stage captures the request; once that stage advances, the record is updated,
// written back and the response loaded into the output register. A request can follow
// every cycle while rsp_stall stays low; a write to a slot that the next request reads
// is forwarded, so back-to-back events on the same slot see each other. Slots at or
// above MAX_POINTS are ignored and return an all-zero response. The csr_ port writes
// flick_threshold (index 0) and hold_time_ms (index 1); write them only while no
// request is in flight.
module touch_gesture_tracker_top #(
   parameter int MAX_POINTS = tgt_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [tgt_pkg::SLOT_W-1:0]          req_slot,
   input  logic signed [tgt_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [tgt_pkg::COORD_W-1:0]  req_pos_y,
   input  logic [tgt_pkg::COORD_W-1:0]         req_contact_size,
   input  logic [tgt_pkg::TIME_W-1:0]          req_time_ms,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tgt_pkg::STATE_W-1:0]         rsp_gesture_state,
   output logic signed [tgt_pkg::COORD_W-1:0]  rsp_cur_x,
   output logic signed [tgt_pkg::COORD_W-1:0]  rsp_cur_y,
   output logic signed [tgt_pkg::COORD_W-1:0]  rsp_last_x,
   output logic signed [tgt_pkg::COORD_W-1:0]  rsp_last_y,
   output logic [tgt_pkg::COORD_W-1:0]         rsp_size_out,
   output logic [tgt_pkg::CLICK_W-1:0]         rsp_clicks,
   output logic                                rsp_active,
   // configuration write port
   input  logic                                csr_we,
   input  logic [tgt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tgt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tgt_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int EXT_W = SLOT_W + IDX_W;

   // configuration registers
   logic [THR_W-1:0]  flick_thr_ff;
   logic [HOLD_W-1:0] hold_time_ff;

   // update stage
   logic              s1_vld_ff;
   logic              s1_in_range_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   evt_type           s1_evt_ff;
   logic              s1_go;

   // response register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rec_type           rsp_rec_ff;
   logic              rsp_active_ff;

   logic              req_take;
   logic [EXT_W-1:0]  slot_ext;
   logic              slot_in_range;
   logic [IDX_W-1:0]  slot_idx;
   rec_type           cur_rec;
   rec_type           nxt_rec;
   logic              nxt_active;
   logic              wr_en;

   assign slot_ext      = EXT_W'(req_slot);
   assign slot_in_range = slot_ext < EXT_W'(MAX_POINTS);
   assign slot_idx      = slot_ext[IDX_W-1:0];

   // advance the update stage when the response register is free or being taken
   assign s1_go     = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_vld_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;
   assign wr_en     = s1_vld_ff && s1_go && s1_in_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flick_thr_ff <= FLICK_THR_RESET;
         hold_time_ff <= HOLD_TIME_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FLICK_THR: flick_thr_ff <= csr_wdata[THR_W-1:0];
            CSR_HOLD_TIME: hold_time_ff <= csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   tgt_slot_mem #(
      .DEPTH (MAX_POINTS),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (req_take && slot_in_range),
      .rd_idx (slot_idx),
      .rd_rec (cur_rec),
      .wr_en  (wr_en),
      .wr_idx (s1_idx_ff),
      .wr_rec (nxt_rec)
   );

   tgt_update u_update (
      .cur_rec   (cur_rec),
      .evt       (s1_evt_ff),
      .flick_thr (flick_thr_ff),
      .hold_time (hold_time_ff),
      .nxt_rec   (nxt_rec),
      .active    (nxt_active)
   );

   // capture the request alongside its memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_go || !s1_vld_ff) begin
         s1_vld_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_in_range_ff         <= slot_in_range;
         s1_idx_ff              <= slot_idx;
         s1_evt_ff.action       <= req_action;
         s1_evt_ff.pos_x        <= req_pos_x;
         s1_evt_ff.pos_y        <= req_pos_y;
         s1_evt_ff.contact_size <= req_contact_size;
         s1_evt_ff.time_ms      <= req_time_ms;
      end
   end

   // hold the response until taken; load the next one from the update stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff && s1_go) begin
         // drop out-of-range slots to an all-zero response
         rsp_rec_ff    <= s1_in_range_ff ? nxt_rec : '0;
         rsp_active_ff <= s1_in_range_ff && nxt_active;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gesture_state = rsp_rec_ff.state;
   assign rsp_cur_x         = $signed(rsp_rec_ff.x);
   assign rsp_cur_y         = $signed(rsp_rec_ff.y);
   assign rsp_last_x        = $signed(rsp_rec_ff.prev_x);
   assign rsp_last_y        = $signed(rsp_rec_ff.prev_y);
   assign rsp_size_out      = rsp_rec_ff.size;
   assign rsp_clicks        = rsp_rec_ff.clicks;
   assign rsp_active        = rsp_active_ff;

endmodule

>>> sv/tgt_slot_mem.sv
// Slot record memory: registered read, per-entry valid bits, write-to-read forwarding.
module tgt_slot_mem #(
   parameter int DEPTH = tgt_pkg::MAX_POINTS_DEFAULT,
   parameter int IDX_W = tgt_pkg::SLOT_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output tgt_pkg::rec_type rd_rec,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  tgt_pkg::rec_type wr_rec
);
   import tgt_pkg::*;

   rec_type          mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   rec_type          rd_data_ff;
   logic             rd_vld_ff;
   logic             fwd_hit_ff;
   rec_type          fwd_rec_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_rec;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
         fwd_rec_ff <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff  <= vld_ff[rd_idx];
            // a write to the same entry on the read edge is not yet in the array
            fwd_hit_ff <= wr_en && (wr_idx == rd_idx);
         end
      end
   end

   // entries never written read as the reset record
   assign rd_rec = fwd_hit_ff ? fwd_rec_ff : (rd_vld_ff ? rd_data_ff : '0);

endmodule

>>> sv/tgt_update.sv
// Gesture update of one slot record for a press, release or tick event.
module tgt_update (
   input  tgt_pkg::rec_type               cur_rec,
   input  tgt_pkg::evt_type               evt,
   input  logic [tgt_pkg::THR_W-1:0]      flick_thr,
   input  logic [tgt_pkg::HOLD_W-1:0]     hold_time,
   output tgt_pkg::rec_type               nxt_rec,
   output logic                           active
);
   import tgt_pkg::*;

   logic [TIME_W-1:0]  elapsed;
   logic               over;
   logic signed [16:0] dx_s;
   logic signed [16:0] dy_s;
   logic [16:0]        dx;
   logic [16:0]        dy;
   logic [10:0]        far;
   logic               beyond_thr;
   logic               beyond_far;
   logic [STATE_W-1:0] tm;

   always_comb begin
      elapsed = evt.time_ms - cur_rec.base_time;
      over    = elapsed > {{(TIME_W-HOLD_W){1'b0}}, hold_time};
      dx_s    = $signed({cur_rec.base_x[15], cur_rec.base_x})
              - $signed({evt.pos_x[15], evt.pos_x});
      dy_s    = $signed({cur_rec.base_y[15], cur_rec.base_y})
              - $signed({evt.pos_y[15], evt.pos_y});
      dx      = dx_s[16] ? 17'(-dx_s) : 17'(dx_s);
      dy      = dy_s[16] ? 17'(-dy_s) : 17'(dy_s);
      far     = {(9'({1'b0, flick_thr}) + 9'd1), 2'b00};
      beyond_thr = (dx > 17'(flick_thr)) || (dy > 17'(flick_thr));
      beyond_far = (dx > 17'(far)) || (dy > 17'(far));

      nxt_rec = cur_rec;
      active  = 1'b0;
      tm      = cur_rec.state;

      case (evt.action)
         ACT_PRESS: begin
            active = cur_rec.state != ST_NONE;
            tm     = cur_rec.state & ~M_CHANGE;
            nxt_rec.prev_x = cur_rec.x;
            nxt_rec.prev_y = cur_rec.y;
            nxt_rec.size   = evt.contact_size;
            if ((tm & M_MOVING) == ST_NONE) begin
               if ((tm & M_TOUCH) != ST_NONE) begin
                  if (beyond_thr) begin
                     nxt_rec.prev_x = cur_rec.base_x;
                     nxt_rec.prev_y = cur_rec.base_y;
                     tm = tm | ST_FLICK_BEGIN;
                  end else if (tm == ST_TOUCH && over) begin
                     tm = ST_HOLD_BEGIN;
                  end
               end else begin
                  // new touch: rebase, drop the click run after a pause or a far jump
                  nxt_rec.x = evt.pos_x;
                  nxt_rec.y = evt.pos_y;
                  tm = ST_TOUCH_BEGIN;
                  if (over || beyond_far) begin
                     nxt_rec.clicks = '0;
                  end
                  nxt_rec.base_time = evt.time_ms;
                  nxt_rec.base_x    = evt.pos_x;
                  nxt_rec.base_y    = evt.pos_y;
                  nxt_rec.prev_x    = evt.pos_x;
                  nxt_rec.prev_y    = evt.pos_y;
               end
            end
            if ((tm & M_MOVING) != ST_NONE) begin
               nxt_rec.x = evt.pos_x;
               nxt_rec.y = evt.pos_y;
            end
         end
         ACT_RELEASE: begin
            if (cur_rec.state != ST_NONE) begin
               active = 1'b1;
               tm     = cur_rec.state & ~M_CHANGE;
               tm     = ((tm & M_TOUCH) != ST_NONE) ? ((tm | M_CHANGE) & ~M_TOUCH) : ST_NONE;
               if (tm == ST_TOUCH_END) begin
                  nxt_rec.base_time = evt.time_ms;
                  nxt_rec.clicks    = cur_rec.clicks + 8'd1;
               end
            end
         end
         ACT_TICK: begin
            if (cur_rec.state != ST_NONE) begin
               active = 1'b1;
               tm     = cur_rec.state;
               if (tm != ST_TOUCH_END) begin
                  tm = tm & ~M_CHANGE;
               end
               if ((tm & M_TOUCH) != ST_NONE) begin
                  nxt_rec.prev_x = cur_rec.x;
                  nxt_rec.prev_y = cur_rec.y;
                  if (tm == ST_TOUCH && over) begin
                     tm = ST_HOLD_BEGIN;
                  end
               end else if (tm != ST_TOUCH_END) begin
                  tm = ST_NONE;
               end
            end
         end
         default: begin
            tm = cur_rec.state;
         end
      endcase

      nxt_rec.state = tm;
   end

endmodule

>>> tb/tb_touch_gesture_tracker_top.sv
// Self-checking testbench for the touch gesture tracker: directed and random gesture streams vs. a slot model.
module tb_touch_gesture_tracker_top;
   import tgt_pkg::*;

   localparam int SLOTS = MAX_POINTS_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   // action code 3 is not defined; the block must read the slot back untouched
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]                action;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0]        contact_size;
      logic [TIME_W-1:0]         time_ms;
   } touch_req_type;

   typedef struct packed {
      logic [STATE_W-1:0]        state;
      logic signed [COORD_W-1:0] cur_x;
      logic signed [COORD_W-1:0] cur_y;
      logic signed [COORD_W-1:0] last_x;
      logic signed [COORD_W-1:0] last_y;
      logic [COORD_W-1:0]        size;
      logic [CLICK_W-1:0]        clicks;
      logic                      active;
   } gesture_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_action = ACT_TICK;
   logic [SLOT_W-1:0]         req_slot = '0;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_y = '0;
   logic [COORD_W-1:0]        req_contact_size = '0;
   logic [TIME_W-1:0]         req_time_ms = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATE_W-1:0]        rsp_gesture_state;
   logic signed [COORD_W-1:0] rsp_cur_x;
   logic signed [COORD_W-1:0] rsp_cur_y;
   logic signed [COORD_W-1:0] rsp_last_x;
   logic signed [COORD_W-1:0] rsp_last_y;
   logic [COORD_W-1:0]        rsp_size_out;
   logic [CLICK_W-1:0]        rsp_clicks;
   logic                      rsp_active;

   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FLICK_THR;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   touch_gesture_tracker_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_slot          (req_slot),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_contact_size  (req_contact_size),
      .req_time_ms       (req_time_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_gesture_state (rsp_gesture_state),
      .rsp_cur_x         (rsp_cur_x),
      .rsp_cur_y         (rsp_cur_y),
      .rsp_last_x        (rsp_last_x),
      .rsp_last_y        (rsp_last_y),
      .rsp_size_out      (rsp_size_out),
      .rsp_clicks        (rsp_clicks),
      .rsp_active        (rsp_active),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   // Requests waiting to be driven, and gesture results the tracker still owes us.
   touch_req_type   pending_events[$];
   gesture_rsp_type expected_gestures[$];

   int          mismatch_count = 0;
   int          rsp_count = 0;
   int unsigned cycles = 0;

   // Idling knobs, switched per phase so some phases run flat out.
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;

   // Register values as the tracker sees them.
   logic [THR_W-1:0]  cfg_thr = FLICK_THR_RESET;
   logic [HOLD_W-1:0] cfg_hold = HOLD_TIME_RESET;

   // Shadow slot records: all zero after reset, no touch anywhere.
   logic [STATE_W-1:0]        trk_state     [SLOTS] = '{default: '0};
   logic signed [COORD_W-1:0] trk_x         [SLOTS] = '{default: '0};
   logic signed [COORD_W-1:0] trk_y         [SLOTS] = '{default: '0};
   logic signed [COORD_W-1:0] trk_prev_x    [SLOTS] = '{default: '0};
   logic signed [COORD_W-1:0] trk_prev_y    [SLOTS] = '{default: '0};
   logic signed [COORD_W-1:0] trk_base_x    [SLOTS] = '{default: '0};
   logic signed [COORD_W-1:0] trk_base_y    [SLOTS] = '{default: '0};
   logic [TIME_W-1:0]         trk_base_time [SLOTS] = '{default: '0};
   logic [CLICK_W-1:0]        trk_clicks    [SLOTS] = '{default: '0};
   logic [COORD_W-1:0]        trk_size      [SLOTS] = '{default: '0};

   // Stimulus-side view of each finger: where its touch started and whether it is down.
   logic signed [COORD_W-1:0] gen_base_x [SLOTS] = '{default: '0};
   logic signed [COORD_W-1:0] gen_base_y [SLOTS] = '{default: '0};
   logic signed [COORD_W-1:0] gen_x      [SLOTS] = '{default: '0};
   logic signed [COORD_W-1:0] gen_y      [SLOTS] = '{default: '0};
   bit                        gen_down   [SLOTS] = '{default: 1'b0};
   logic [TIME_W-1:0]         gen_now = 32'hFFFF_0000;

   function automatic int coord_dist(logic signed [COORD_W-1:0] a,
                                     logic signed [COORD_W-1:0] b);
      int d;
      d = int'(a) - int'(b);
      return (d < 0) ? -d : d;
   endfunction

   // Apply one event to the shadow slot record and return the result it must produce.
   function automatic gesture_rsp_type track_event(touch_req_type ev);
      gesture_rsp_type r;
      logic [STATE_W-1:0] tm;
      logic [TIME_W-1:0]  held;
      logic [TIME_W-1:0]  hold_lim;
      logic [SLOT_W-1:0]  s;
      int thr_i, far_i, dx, dy;
      logic was_active;
      s = ev.slot;
      thr_i = int'(cfg_thr);
      far_i = (thr_i + 1) * 4;
      hold_lim = TIME_W'(cfg_hold);
      held = ev.time_ms - trk_base_time[s];
      dx = coord_dist(trk_base_x[s], ev.pos_x);
      dy = coord_dist(trk_base_y[s], ev.pos_y);
      was_active = (trk_state[s] != ST_NONE);
      case (ev.action)
         ACT_PRESS: begin
            tm = trk_state[s] & ~M_CHANGE;
            trk_prev_x[s] = trk_x[s];
            trk_prev_y[s] = trk_y[s];
            trk_size[s] = ev.contact_size;
            if ((tm & M_MOVING) == ST_NONE) begin
               if ((tm & M_TOUCH) != ST_NONE) begin
                  // moved past the threshold: report the base as the last position
                  if (dx > thr_i || dy > thr_i) begin
                     trk_prev_x[s] = trk_base_x[s];
                     trk_prev_y[s] = trk_base_y[s];
                     tm = tm | ST_FLICK_BEGIN;
                  end else if (tm == ST_TOUCH && held > hold_lim) begin
                     tm = ST_HOLD_BEGIN;
                  end
               end else begin
                  // new touch: drop the click run after a long pause or a far touch
                  trk_x[s] = ev.pos_x;
                  trk_y[s] = ev.pos_y;
                  tm = ST_TOUCH_BEGIN;
                  if (held > hold_lim || dx > far_i || dy > far_i)
                     trk_clicks[s] = '0;
                  trk_base_time[s] = ev.time_ms;
                  trk_base_x[s] = ev.pos_x;
                  trk_base_y[s] = ev.pos_y;
                  trk_prev_x[s] = ev.pos_x;
                  trk_prev_y[s] = ev.pos_y;
               end
            end
            if ((tm & M_MOVING) != ST_NONE) begin
               trk_x[s] = ev.pos_x;
               trk_y[s] = ev.pos_y;
            end
            trk_state[s] = tm;
         end
         ACT_RELEASE: begin
            if (was_active) begin
               tm = trk_state[s] & ~M_CHANGE;
               tm = ((tm & M_TOUCH) != ST_NONE) ? ((tm | M_CHANGE) & ~M_TOUCH) : ST_NONE;
               if (tm == ST_TOUCH_END) begin
                  trk_base_time[s] = ev.time_ms;
                  trk_clicks[s] = trk_clicks[s] + 8'd1;
               end
               trk_state[s] = tm;
            end
         end
         ACT_TICK: begin
            if (was_active) begin
               tm = trk_state[s];
               // a plain touch end stays visible until the next press or release
               if (tm != ST_TOUCH_END)
                  tm = tm & ~M_CHANGE;
               if ((tm & M_TOUCH) != ST_NONE) begin
                  trk_prev_x[s] = trk_x[s];
                  trk_prev_y[s] = trk_y[s];
                  if (tm == ST_TOUCH && held > hold_lim)
                     tm = ST_HOLD_BEGIN;
               end else if (tm != ST_TOUCH_END) begin
                  tm = ST_NONE;
               end
               trk_state[s] = tm;
            end
         end
         default: ;
      endcase
      r.state  = trk_state[s];
      r.cur_x  = trk_x[s];
      r.cur_y  = trk_y[s];
      r.last_x = trk_prev_x[s];
      r.last_y = trk_prev_y[s];
      r.size   = trk_size[s];
      r.clicks = trk_clicks[s];
      r.active = (ev.action == ACT_PRESS || ev.action == ACT_RELEASE ||
                  ev.action == ACT_TICK) ? was_active : 1'b0;
      return r;
   endfunction

   function automatic int signed_pick(int m);
      return int'($urandom_range(2 * m)) - m;
   endfunction

   function automatic int edge_pick(int m);
      return ($urandom_range(1) != 0) ? m : -m;
   endfunction

   // Next event of a plausible finger stream: press, move, hold, lift, tap again.
   // A slice of pure noise keeps the odd cases (action 3, wild times) coming.
   function automatic touch_req_type make_gesture_event();
      touch_req_type ev;
      logic [SLOT_W-1:0] s;
      int thr_i, far_i, roll;
      thr_i = int'(cfg_thr);
      far_i = (thr_i + 1) * 4;
      roll = $urandom_range(99);
      if (roll < 55)
         gen_now = gen_now + $urandom_range(20);
      else if (roll < 80)
         gen_now = gen_now + TIME_W'(cfg_hold) + $urandom_range(2) - 1;
      else if (roll < 95)
         gen_now = gen_now + $urandom_range(2 * int'(cfg_hold) + 2);
      else
         gen_now = gen_now + $urandom;
      ev.time_ms = gen_now;
      ev.contact_size = COORD_W'($urandom);
      if ($urandom_range(99) < 15) begin
         ev.action = 2'($urandom_range(3));
         ev.slot   = SLOT_W'($urandom_range(SLOTS - 1));
         ev.pos_x  = COORD_W'($urandom);
         ev.pos_y  = COORD_W'($urandom);
         if ($urandom_range(1) != 0)
            ev.time_ms = $urandom;
         return ev;
      end
      // favor a few slots so gestures on one finger run long enough to mature
      s = SLOT_W'(($urandom_range(1) != 0) ? $urandom_range(2) : $urandom_range(SLOTS - 1));
      ev.slot = s;
      ev.action = ACT_PRESS;
      ev.pos_x = gen_x[s];
      ev.pos_y = gen_y[s];
      if (!gen_down[s]) begin
         case ($urandom_range(3))
            0: begin
               ev.pos_x = COORD_W'(int'(gen_base_x[s]) + signed_pick(far_i));
               ev.pos_y = COORD_W'(int'(gen_base_y[s]) + signed_pick(far_i));
            end
            1: begin
               ev.pos_x = COORD_W'(int'(gen_base_x[s]) + edge_pick(far_i + 1));
               ev.pos_y = COORD_W'(int'(gen_base_y[s]) + signed_pick(far_i));
            end
            2: begin
               ev.pos_x = COORD_W'($urandom);
               ev.pos_y = COORD_W'($urandom);
            end
            default: begin
               ev.pos_x = COORD_W'(int'(gen_base_x[s]) + signed_pick(far_i));
               ev.pos_y = COORD_W'(int'(gen_base_y[s]) + edge_pick(far_i));
            end
         endcase
         gen_base_x[s] = ev.pos_x;
         gen_base_y[s] = ev.pos_y;
         gen_down[s] = 1'b1;
      end else begin
         roll = $urandom_range(99);
         if (roll < 15) begin
            ev.action = ACT_RELEASE;
            gen_down[s] = 1'b0;
         end else if (roll < 30) begin
            ev.action = ACT_TICK;
         end else if (roll < 55) begin
            ev.pos_x = COORD_W'(int'(gen_base_x[s]) + signed_pick(thr_i));
            ev.pos_y = COORD_W'(int'(gen_base_y[s]) + signed_pick(thr_i));
         end else if (roll < 75) begin
            ev.pos_x = COORD_W'(int'(gen_base_x[s]) +
                                edge_pick(thr_i + int'($urandom_range(1))));
            ev.pos_y = COORD_W'(int'(gen_base_y[s]) + signed_pick(thr_i));
         end else begin
            ev.pos_x = COORD_W'(int'(gen_x[s]) + signed_pick(600));
            ev.pos_y = COORD_W'(int'(gen_y[s]) + signed_pick(600));
         end
      end
      gen_x[s] = ev.pos_x;
      gen_y[s] = ev.pos_y;
      return ev;
   endfunction

   task automatic queue_event(logic [1:0] action, int slot, int x, int y, int sz,
                              logic [TIME_W-1:0] t);
      touch_req_type ev;
      ev.action       = action;
      ev.slot         = SLOT_W'(slot);
      ev.pos_x        = COORD_W'(x);
      ev.pos_y        = COORD_W'(y);
      ev.contact_size = COORD_W'(sz);
      ev.time_ms      = t;
      pending_events.push_back(ev);
   endtask

   // Hold until every queued request is out and every result is back.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_events.size() != 0 || req_valid || expected_gestures.size() != 0);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FLICK_THR)
         cfg_thr = val[THR_W-1:0];
      else
         cfg_hold = val[HOLD_W-1:0];
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (!tx_idle_on || roll < 70)
         return 0;
      if (roll < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Request driver: predict each accepted request, then present the next one
   // after its gap. A stalled request holds its payload.
   int tx_gap = 0;

   always @(posedge clock) begin : request_driver
      touch_req_type on_bus;
      touch_req_type nxt;
      bit take;
      take = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            on_bus.action       = req_action;
            on_bus.slot         = req_slot;
            on_bus.pos_x        = req_pos_x;
            on_bus.pos_y        = req_pos_y;
            on_bus.contact_size = req_contact_size;
            on_bus.time_ms      = req_time_ms;
            expected_gestures.push_back(track_event(on_bus));
         end
         if (!req_valid || !req_stall) begin
            if (tx_gap > 0)
               tx_gap <= tx_gap - 1;
            else if (pending_events.size() != 0)
               take = 1'b1;
            if (take) begin
               nxt = pending_events.pop_front();
               req_action       <= nxt.action;
               req_slot         <= nxt.slot;
               req_pos_x        <= nxt.pos_x;
               req_pos_y        <= nxt.pos_y;
               req_contact_size <= nxt.contact_size;
               req_time_ms      <= nxt.time_ms;
               tx_gap <= pick_gap();
            end
            req_valid <= take;
         end
      end
   end

   // Response back-pressure. Once, early on, freeze for a long stretch so the
   // pipeline backs up into req_stall while the driver keeps offering requests.
   int rx_hold = 0;
   bit rx_froze = 1'b0;

   always @(posedge clock) begin : response_stall
      int roll;
      roll = $urandom_range(99);
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_hold <= 0;
      end else if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp_stall <= 1'b1;
      end else if (!rx_froze && rsp_count >= 40) begin
         rx_froze <= 1'b1;
         rx_hold <= 150;
         rsp_stall <= 1'b1;
      end else if (rx_idle_on && roll >= 75) begin
         rx_hold <= (roll < 95) ? $urandom_range(2) : $urandom_range(40, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at response %0d: %s", rsp_count, msg);
   endtask

   // Response checker: compare every accepted response with the oldest prediction.
   always @(posedge clock) begin : response_check
      gesture_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count <= rsp_count + 1;
         if (expected_gestures.size() == 0) begin
            note_mismatch("response with no request outstanding");
         end else begin
            want = expected_gestures.pop_front();
            if (rsp_gesture_state !== want.state)
               note_mismatch($sformatf("gesture_state expected %0d got %0d",
                                       want.state, rsp_gesture_state));
            if (rsp_cur_x !== want.cur_x)
               note_mismatch($sformatf("cur_x expected %0d got %0d", want.cur_x, rsp_cur_x));
            if (rsp_cur_y !== want.cur_y)
               note_mismatch($sformatf("cur_y expected %0d got %0d", want.cur_y, rsp_cur_y));
            if (rsp_last_x !== want.last_x)
               note_mismatch($sformatf("last_x expected %0d got %0d", want.last_x, rsp_last_x));
            if (rsp_last_y !== want.last_y)
               note_mismatch($sformatf("last_y expected %0d got %0d", want.last_y, rsp_last_y));
            if (rsp_size_out !== want.size)
               note_mismatch($sformatf("size_out expected %0d got %0d", want.size, rsp_size_out));
            if (rsp_clicks !== want.clicks)
               note_mismatch($sformatf("clicks expected %0d got %0d", want.clicks, rsp_clicks));
            if (rsp_active !== want.active)
               note_mismatch($sformatf("active expected %0d got %0d", want.active, rsp_active));
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      int p;
      logic [THR_W-1:0]  thr_v;
      logic [HOLD_W-1:0] hold_v;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed pass with reset registers (threshold 8, hold 500).
      // Idle slot: tick, release and the undefined action change nothing.
      queue_event(ACT_TICK,    0, 100, 100, 7, 32'hFFFF_FF00);
      queue_event(ACT_RELEASE, 0, 100, 100, 7, 32'hFFFF_FF00);
      queue_event(ACT_UNUSED,  0, 32767, -32768, 16'hFFFF, 32'hFFFF_FF00);
      // Touch at the coordinate extremes, sit still, then hold across the time wrap.
      queue_event(ACT_PRESS,   0, -32768, 32767, 16'hFFFF, 32'hFFFF_FF00);
      queue_event(ACT_PRESS,   0, -32768, 32767, 1, 32'hFFFF_FF64);
      queue_event(ACT_UNUSED,  0, 0, 0, 0, 32'hFFFF_FF70);
      queue_event(ACT_TICK,    0, 0, 0, 0, 32'h0000_00F5);
      queue_event(ACT_PRESS,   0, -32768, 32767, 2, 32'h0000_0158);
      // Drag out of the hold, keep dragging, lift: drag end then idle.
      queue_event(ACT_PRESS,   0, -32759, 32767, 3, 32'h0000_0160);
      queue_event(ACT_PRESS,   0, -32728, 32727, 4, 32'h0000_0170);
      queue_event(ACT_TICK,    0, 0, 0, 0, 32'h0000_0180);
      queue_event(ACT_RELEASE, 0, 0, 0, 0, 32'h0000_0190);
      queue_event(ACT_TICK,    0, 0, 0, 0, 32'h0000_01A0);
      // Flick: a move of exactly the threshold stays a touch, one more starts it.
      queue_event(ACT_PRESS,   1, 32767, -32768, 0, 20);
      queue_event(ACT_PRESS,   1, 32759, -32768, 5, 22);
      queue_event(ACT_PRESS,   1, 32767, -32759, 6, 24);
      queue_event(ACT_RELEASE, 1, 0, 0, 0, 26);
      // Press right after a flick end keeps the moving bit; release clears it.
      queue_event(ACT_PRESS,   1, 32767, -32768, 8, 30);
      queue_event(ACT_RELEASE, 1, 0, 0, 0, 32);
      // Taps: touch end survives a tick, a pause of exactly hold and a distance of
      // exactly four steps keep the count, one pixel further clears it.
      queue_event(ACT_PRESS,   2, 0, 0, 9, 1000);
      queue_event(ACT_RELEASE, 2, 0, 0, 0, 1010);
      queue_event(ACT_TICK,    2, 0, 0, 0, 1020);
      queue_event(ACT_PRESS,   2, 36, -36, 10, 1510);
      queue_event(ACT_RELEASE, 2, 0, 0, 0, 1520);
      queue_event(ACT_PRESS,   2, 73, 0, 11, 1530);

      // Random phases, each under its own register setting; the extremes come first.
      for (p = 0; p < 5; p++) begin
         wait_drained();
         case (p)
            0: begin thr_v = 8'd0;   hold_v = 16'd0;     end
            1: begin thr_v = 8'd255; hold_v = 16'hFFFF;  end
            2: begin thr_v = 8'd20;  hold_v = 16'd100;   end
            3: begin thr_v = 8'($urandom); hold_v = 16'($urandom); end
            default: begin thr_v = 8'd3; hold_v = 16'd1000; end
         endcase
         // upper byte of the threshold write is don't-care; drive junk there
         write_csr(CSR_FLICK_THR, {8'($urandom), thr_v});
         write_csr(CSR_HOLD_TIME, hold_v);
         @(negedge clock);
         tx_idle_on = (p != 2);
         rx_idle_on = (p != 2) && (p != 3);
         repeat (100) pending_events.push_back(make_gesture_event());
      end

      wait_drained();
      // catch any stray response before calling it
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_gestures.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
